### design/text_cursor_glyph_placer_top_macros.svh
// Assertion macros used by the checker file.
`ifndef TEXT_CURSOR_GLYPH_PLACER_TOP_MACROS_SVH
`define TEXT_CURSOR_GLYPH_PLACER_TOP_MACROS_SVH

// Implication in the same cycle, sampled on clk, off during reset.
`define TCGP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcgp assertion failed");

// Implication in the next cycle, sampled on clk, off during reset.
`define TCGP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcgp assertion failed");

`endif

### design/tcgp_pkg.sv
// Shared types and constants of the text cursor glyph placer.
package tcgp_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 11;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 64;
  localparam int POS_W      = 15;
  localparam int STEP_W     = 4;
  localparam int REM_W      = 11;

  localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_CODE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LAST_CODE    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GLYPH_WIDTH  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_GLYPH_HEIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SHEET_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPACING      = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_INK_COLORS   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_PAPER_COLOR  = 3'd7;

  localparam logic       OP_SET_CURSOR = 1'b1;
  localparam logic [7:0] CHAR_NL       = 8'd10;
  localparam logic [7:0] CHAR_CR       = 8'd13;
  localparam logic [4:0] PAPER_CLEAR   = 5'd16;

  localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(POS_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_SHADOW,
    ST_MAIN
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul;
    logic emit_shadow;
    logic emit_main;
  } tcgp_cmd_t;

  typedef struct packed {
    logic draw;
    logic shadow;
    logic div_last;
    logic out_free;
  } tcgp_sts_t;

endpackage

### design/tcgp_ctl.sv
// Controller state machine of the text cursor glyph placer.
module tcgp_ctl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  tcgp_pkg::tcgp_sts_t sts,
  output tcgp_pkg::tcgp_cmd_t cmd
);

  tcgp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcgp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcgp_pkg::ST_IDLE: begin
        if (in_tvalid && sts.draw) begin
          state_nxt = tcgp_pkg::ST_DIV;
        end
      end
      tcgp_pkg::ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = tcgp_pkg::ST_MUL;
        end
      end
      tcgp_pkg::ST_MUL: begin
        state_nxt = sts.shadow ? tcgp_pkg::ST_SHADOW : tcgp_pkg::ST_MAIN;
      end
      tcgp_pkg::ST_SHADOW: begin
        if (sts.out_free) begin
          state_nxt = tcgp_pkg::ST_MAIN;
        end
      end
      tcgp_pkg::ST_MAIN: begin
        if (sts.out_free) begin
          state_nxt = tcgp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcgp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      tcgp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      tcgp_pkg::ST_DIV:    cmd.div_step    = 1'b1;
      tcgp_pkg::ST_MUL:    cmd.mul         = 1'b1;
      tcgp_pkg::ST_SHADOW: cmd.emit_shadow = sts.out_free;
      tcgp_pkg::ST_MAIN:   cmd.emit_main   = sts.out_free;
      default: ;
    endcase
  end

endmodule

### design/tcgp_dp.sv
// Datapath: configuration, cursor, serial divider, multiplier and output register.
module tcgp_dp #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [tcgp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [tcgp_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [0:0]                          in_tuser,
  input  logic [tcgp_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [tcgp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [0:0]                          out_tuser,
  output logic                                out_tlast,
  input  tcgp_pkg::tcgp_cmd_t                 cmd,
  output tcgp_pkg::tcgp_sts_t                 sts
);

  logic [7:0]  first_code_r, last_code_r;
  logic [6:0]  glyph_width_r;
  logic [5:0]  glyph_height_r;
  logic [10:0] sheet_width_r;
  logic [5:0]  spacing_r;
  logic [8:0]  ink_colors_r;
  logic [4:0]  paper_color_r;

  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;

  logic [7:0]                     base_x_r, base_y_r;
  logic [tcgp_pkg::POS_W-1:0]     pos_r;
  logic [tcgp_pkg::POS_W-1:0]     quo_r;
  logic [tcgp_pkg::REM_W-1:0]     acc_r;
  logic [tcgp_pkg::STEP_W-1:0]    step_r;
  logic [15:0]                    sy_r;

  logic                           out_valid_r;
  logic [tcgp_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                           out_trans_r, out_trans_nxt;
  logic                           out_last_r, out_last_nxt;

  logic        op;
  logic [7:0]  ch, new_col, new_row;
  logic        blocked, in_range, wraps, transparent;
  logic [7:0]  line_step, col_adv;
  logic [10:0] row_lim, col_lim;
  logic [7:0]  code_off;
  logic [tcgp_pkg::POS_W-1:0] pos;
  logic [tcgp_pkg::REM_W:0]   rem_shift;
  logic [tcgp_pkg::REM_W+1:0] diff;
  logic [15:0] quo_fin;
  logic [21:0] prod;
  logic [9:0]  sheet_x;
  logic [7:0]  dx, dy, color;

  assign op      = in_tuser[0];
  assign ch      = in_tdata[7:0];
  assign new_col = in_tdata[15:8];
  assign new_row = in_tdata[23:16];

  assign transparent = (paper_color_r == tcgp_pkg::PAPER_CLEAR);
  assign line_step   = {2'b00, glyph_height_r} + {2'b00, spacing_r};
  assign col_adv     = col_r + {1'b0, glyph_width_r} + {2'b00, spacing_r};
  assign row_lim     = 11'(SCREEN_HEIGHT - 1) - {5'b0, glyph_height_r};
  assign col_lim     = 11'(SCREEN_WIDTH - 1) - {4'b0, glyph_width_r};
  assign blocked     = $signed({3'b000, row_r}) > $signed(row_lim);
  assign wraps       = $signed({3'b000, col_adv}) > $signed(col_lim);
  assign in_range    = (ch >= first_code_r) && (ch <= last_code_r);
  assign code_off    = ch - first_code_r;
  assign pos         = {7'b0, code_off} * {8'b0, glyph_width_r};

  assign rem_shift = {acc_r, quo_r[tcgp_pkg::POS_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, sheet_width_r};
  assign quo_fin   = (sheet_width_r == '0) ? 16'hFFFF : {1'b0, quo_r};
  assign prod      = quo_fin * glyph_height_r;
  assign sheet_x   = (sheet_width_r == '0) ? pos_r[9:0] : acc_r[9:0];

  assign sts.draw     = (op != tcgp_pkg::OP_SET_CURSOR) && !blocked &&
                        (ch != tcgp_pkg::CHAR_NL) && (ch != tcgp_pkg::CHAR_CR) &&
                        in_range;
  assign sts.shadow   = transparent && ink_colors_r[8];
  assign sts.div_last = (step_r == tcgp_pkg::DIV_LAST_STEP);
  assign sts.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_code_r   <= 8'd32;
      last_code_r    <= 8'd127;
      glyph_width_r  <= 7'd6;
      glyph_height_r <= 6'd8;
      sheet_width_r  <= 11'd128;
      spacing_r      <= 6'd0;
      ink_colors_r   <= 9'd15;
      paper_color_r  <= 5'd16;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        tcgp_pkg::CFG_FIRST_CODE:   first_code_r   <= cfg_wdata[7:0];
        tcgp_pkg::CFG_LAST_CODE:    last_code_r    <= cfg_wdata[7:0];
        tcgp_pkg::CFG_GLYPH_WIDTH:  glyph_width_r  <= cfg_wdata[6:0];
        tcgp_pkg::CFG_GLYPH_HEIGHT: glyph_height_r <= cfg_wdata[5:0];
        tcgp_pkg::CFG_SHEET_WIDTH:  sheet_width_r  <= cfg_wdata;
        tcgp_pkg::CFG_SPACING:      spacing_r      <= cfg_wdata[5:0];
        tcgp_pkg::CFG_INK_COLORS:   ink_colors_r   <= cfg_wdata[8:0];
        tcgp_pkg::CFG_PAPER_COLOR:  paper_color_r  <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.load) begin
      if (op == tcgp_pkg::OP_SET_CURSOR) begin
        col_nxt = new_col;
        row_nxt = new_row;
      end else if (!blocked) begin
        if (ch == tcgp_pkg::CHAR_NL) begin
          col_nxt = '0;
          row_nxt = row_r + line_step;
        end else if (ch == tcgp_pkg::CHAR_CR) begin
          col_nxt = '0;
        end else if (wraps) begin
          col_nxt = '0;
          row_nxt = row_r + line_step;
        end else begin
          col_nxt = col_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_x_r <= col_r;
      base_y_r <= row_r;
      pos_r    <= pos;
      quo_r    <= pos;
      acc_r    <= '0;
      step_r   <= '0;
    end else if (cmd.div_step) begin
      step_r <= step_r + 1'b1;
      if (!diff[tcgp_pkg::REM_W+1]) begin
        acc_r <= diff[tcgp_pkg::REM_W-1:0];
        quo_r <= {quo_r[tcgp_pkg::POS_W-2:0], 1'b1};
      end else begin
        acc_r <= rem_shift[tcgp_pkg::REM_W-1:0];
        quo_r <= {quo_r[tcgp_pkg::POS_W-2:0], 1'b0};
      end
    end
    if (cmd.mul) begin
      sy_r <= prod[15:0];
    end
  end

  always_comb begin
    if (cmd.emit_shadow) begin
      dx            = base_x_r + 8'd1;
      dy            = base_y_r + 8'd1;
      color         = {ink_colors_r[7:4], 4'h0};
      out_last_nxt  = 1'b0;
      out_trans_nxt = 1'b1;
    end else begin
      dx            = base_x_r;
      dy            = base_y_r;
      color         = {ink_colors_r[3:0], transparent ? 4'h0 : paper_color_r[3:0]};
      out_last_nxt  = 1'b1;
      out_trans_nxt = transparent;
    end
    out_data_nxt = {1'b0, color, glyph_height_r, glyph_width_r, sy_r, sheet_x, dy, dx};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_shadow || cmd.emit_main) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_shadow || cmd.emit_main) begin
      out_data_r  <= out_data_nxt;
      out_trans_r <= out_trans_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_trans_r;
  assign out_tlast    = out_last_r;

endmodule

### design/text_cursor_glyph_placer_top.sv
// A drawn character passes the 15-step serial divider, the multiply step and the emit
//   steps; the next character is accepted only after its last draw item is emitted,
//   and an emit waits while the output register is held by out_tready.
// Set-cursor, newline, return and undrawn characters are handled in the idle state.
// Reset: synchronous active-low; cursor clears, configuration registers load their defaults.
module text_cursor_glyph_placer_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [tcgp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tcgp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // char_code[7:0], new_column[15:8], new_row[23:16]
  input  logic [tcgp_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic [0:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // dest_x[7:0], dest_y[15:8], sheet_x[25:16], sheet_y[41:26],
  // draw_width[48:42], draw_height[54:49], color_byte[62:55], zero[63]
  output logic [tcgp_pkg::OUT_DATA_W-1:0] out_tdata,
  // transparent[0]
  output logic [0:0]                      out_tuser,
  output logic                            out_tlast
);

  tcgp_pkg::tcgp_cmd_t cmd;
  tcgp_pkg::tcgp_sts_t sts;

  tcgp_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tcgp_dp #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### design/tcgp_chk.sv
// Port checker for the text cursor glyph placer and its bind.
`include "text_cursor_glyph_placer_top_macros.svh"

module tcgp_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_wr_en,
  input logic [tcgp_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [tcgp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [tcgp_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [tcgp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser,
  input logic                            out_tlast
);

  `TCGP_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  `TCGP_ASSERT_NXT(a_out_stable, out_tvalid && !out_tready, $stable(out_tdata))
  `TCGP_ASSERT_IMP(a_shadow_clear, out_tvalid && !out_tlast, out_tuser[0])
  `TCGP_ASSERT_IMP(a_shadow_busy, out_tvalid && !out_tlast, !in_tready)
  `TCGP_ASSERT_IMP(a_clear_nibble, out_tvalid && out_tuser[0], out_tdata[58:55] == 4'h0)

endmodule

bind text_cursor_glyph_placer_top tcgp_chk u_tcgp_chk (.*);
